/* src/utg_pkg.sv */
// Package for the UTF-8 text to glyph index unit.
// Holds the table codes, glyph constants, default text limit and the glyph result type.
// No dependencies; used by utg_glyph_map, utf8_text_to_glyph_index_unit and utg_checker.
`default_nettype none

package utg_pkg;

  // Default limit on the bytes of one text.
  localparam int unsigned MAX_TEXT_BYTES_DEF = 1024;

  // Font table codes.
  localparam logic [1:0] TABLE_PROP  = 2'd0;
  localparam logic [1:0] TABLE_FIXED = 2'd1;
  localparam logic [1:0] TABLE_COLON = 2'd2;

  // Forced widths; zero means the proportional font's stored width.
  localparam logic [2:0] WIDTH_STORED = 3'd0;
  localparam logic [2:0] WIDTH_NARROW = 3'd4;
  localparam logic [2:0] WIDTH_FIXED  = 3'd5;

  // Glyph numbers with a meaning of their own.
  localparam logic [7:0] GLYPH_UNKNOWN = 8'd162;
  localparam logic [7:0] GLYPH_SPACE   = 8'd0;

  // Width of the character counter and the character number field.
  localparam int unsigned CHAR_W = 10;

  // One mapped character.
  typedef struct packed {
    logic [1:0] table_sel;
    logic [7:0] index;
    logic [2:0] width;
  } glyph_t;

endpackage : utg_pkg

`default_nettype wire

/* src/utg_glyph_map.sv */
// Glyph lookup for one complete packed character code.
// Depends on utg_pkg for the table codes and the glyph result type.
`default_nettype none

module utg_glyph_map
  import utg_pkg::*;
(
  input  wire logic [31:0] code,
  input  wire logic        fixed_font,
  output glyph_t           glyph
);

  logic [7:0] font_index;

  // Map the code to a glyph number within a font table.
  always_comb begin
    if (code >= 32'd10 && code <= 32'd31) begin
      font_index = GLYPH_UNKNOWN;
    end else if (code >= 32'd32 && code < 32'h7f) begin
      font_index = code[7:0] - 8'd32;
    end else if (code >= 32'hd090 && code <= 32'hd0bf) begin
      font_index = code[7:0] - 8'h90 + 8'd95;
    end else if (code >= 32'hd180 && code <= 32'hd18f) begin
      font_index = code[7:0] - 8'h80 + 8'd143;
    end else if (code == 32'hd081) begin
      font_index = 8'd159;
    end else if (code == 32'hd191) begin
      font_index = 8'd160;
    end else if (code >= 32'hd084 && code <= 32'hd087) begin
      font_index = code[7:0] - 8'h84 + 8'd161;
    end else if (code >= 32'hd194 && code <= 32'hd197) begin
      font_index = code[7:0] - 8'h94 + 8'd165;
    end else if (code == 32'hd290 || code == 32'hd291) begin
      font_index = code[7:0] - 8'h90 + 8'd169;
    end else if (code == 32'hc2b0) begin
      font_index = 8'd171;
    end else if (code == 32'hc2ab || code == 32'hc2bb ||
                 (code >= 32'he2809c && code <= 32'he2809f)) begin
      font_index = 8'd2;
    end else if (code >= 32'he28098 && code <= 32'he2809b) begin
      font_index = 8'd7;
    end else if (code >= 32'he28090 && code <= 32'he28095) begin
      font_index = 8'd13;
    end else if (code == 32'he280a6) begin
      font_index = 8'd172;
    end else if (code == 32'hc2a0) begin
      font_index = 8'd0;
    end else if (code == 32'he28496) begin
      font_index = 8'd3;
    end else begin
      font_index = GLYPH_UNKNOWN;
    end
  end

  // Pick the table and width; the colon set and the space glyph override the font.
  always_comb begin
    if (code >= 32'd1 && code <= 32'd9) begin
      glyph.table_sel = TABLE_COLON;
      glyph.index     = code[7:0] - 8'd1;
      glyph.width     = WIDTH_NARROW;
    end else if (code == 32'h7f) begin
      glyph.table_sel = TABLE_PROP;
      glyph.index     = GLYPH_SPACE;
      glyph.width     = WIDTH_NARROW;
    end else begin
      glyph.table_sel = fixed_font ? TABLE_FIXED : TABLE_PROP;
      glyph.index     = font_index;
      glyph.width     = fixed_font ? WIDTH_FIXED : WIDTH_STORED;
    end
  end

endmodule : utg_glyph_map

`default_nettype wire

/* src/utf8_text_to_glyph_index_unit.sv */
// Top level of the UTF-8 text to glyph index unit: byte collection, counters, result register.
// Depends on utg_pkg and instantiates utg_glyph_map.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     in_text_byte[7:0]
//   out      output     out_valid / out_ready   out_glyph_table, out_glyph_index,
//                                               out_width_override, out_char_number
//   cfg      input      cfg_valid / cfg_ready   cfg_fixed_width_font
//
// One byte is taken per cycle; a completed character is loaded into the result register
// in the cycle after the transfer of its last byte. The only stall is a full result
// register that is not being drained in the same cycle. Reset is synchronous and
// active low; it clears the pending count, both counters, the font select and the
// result valid flag. The configuration port is always ready.
`default_nettype none

module utf8_text_to_glyph_index_unit
  import utg_pkg::*;
#(
  parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_text_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_glyph_table,
  output logic [7:0]             out_glyph_index,
  output logic [2:0]             out_width_override,
  output logic [CHAR_W-1:0]      out_char_number,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_fixed_width_font
);

  localparam int unsigned BC_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [BC_W-1:0] BC_MAX = BC_W'(MAX_TEXT_BYTES);

  logic              fixed_r, fixed_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [31:0]       packed_r, packed_nxt;
  logic [CHAR_W-1:0] chars_r, chars_nxt;
  logic [BC_W-1:0]   bytes_r, bytes_nxt;
  logic              out_valid_r, out_valid_nxt;
  glyph_t            glyph_r, glyph_nxt;
  logic [CHAR_W-1:0] num_r, num_nxt;

  logic       in_xfer;
  logic       emit;
  logic [31:0] code;
  glyph_t     glyph;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  // Glyph lookup of the character completed by this byte.
  utg_glyph_map u_map (
    .code       (code),
    .fixed_font (fixed_r),
    .glyph      (glyph)
  );

  // Byte collection and counters.
  always_comb begin
    fixed_nxt  = cfg_valid ? cfg_fixed_width_font : fixed_r;
    pend_nxt   = pend_r;
    packed_nxt = packed_r;
    chars_nxt  = chars_r;
    bytes_nxt  = bytes_r;
    emit       = 1'b0;
    code       = {24'd0, in_text_byte};
    if (in_xfer) begin
      if (in_text_byte == 8'd0) begin
        // Terminator drops any partial character and starts a new text.
        pend_nxt  = 2'd0;
        chars_nxt = '0;
        bytes_nxt = '0;
      end else if (pend_r != 2'd0) begin
        // Continuation bytes are appended without checking their top bits.
        code       = {packed_r[23:0], in_text_byte};
        packed_nxt = code;
        pend_nxt   = pend_r - 2'd1;
        if (bytes_r < BC_MAX) begin
          bytes_nxt = bytes_r + 1'b1;
        end
        emit = (pend_r == 2'd1);
      end else if (bytes_r < BC_MAX) begin
        bytes_nxt = bytes_r + 1'b1;
        if (in_text_byte[7:5] == 3'b110) begin
          packed_nxt = code;
          pend_nxt   = 2'd1;
        end else if (in_text_byte[7:4] == 4'b1110) begin
          packed_nxt = code;
          pend_nxt   = 2'd2;
        end else if (in_text_byte[7:3] == 5'b11110) begin
          packed_nxt = code;
          pend_nxt   = 2'd3;
        end else begin
          // Single-byte character, including stray continuation bytes.
          emit = 1'b1;
        end
      end
      if (emit) begin
        chars_nxt = chars_r + 1'b1;
      end
    end
  end

  // Result register: loaded on a completed character, cleared when taken.
  always_comb begin
    glyph_nxt     = glyph_r;
    num_nxt       = num_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      glyph_nxt     = glyph;
      num_nxt       = chars_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_r     <= 1'b0;
      pend_r      <= 2'd0;
      chars_r     <= '0;
      bytes_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fixed_r     <= fixed_nxt;
      pend_r      <= pend_nxt;
      chars_r     <= chars_nxt;
      bytes_r     <= bytes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    packed_r <= packed_nxt;
    glyph_r  <= glyph_nxt;
    num_r    <= num_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_glyph_table    = glyph_r.table_sel;
  assign out_glyph_index    = glyph_r.index;
  assign out_width_override = glyph_r.width;
  assign out_char_number    = num_r;

endmodule : utf8_text_to_glyph_index_unit

`default_nettype wire

/* src/utg_checker.sv */
// Port-level checks for the UTF-8 text to glyph index unit, bound to its top level.
// Depends on utg_pkg for the table and width codes.
`default_nettype none

module utg_checker
  import utg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_text_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_glyph_table,
  input wire logic [7:0] out_glyph_index,
  input wire logic [2:0] out_width_override
);

  // A waiting result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A terminator gives no result in the following cycle.
  a_term_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_text_byte == 8'd0 |=> !out_valid)
    else $error("result after terminator");

  // The colon set always has the narrow width and only nine glyphs.
  a_colon_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_glyph_table == TABLE_COLON |->
      out_width_override == WIDTH_NARROW && out_glyph_index <= 8'd8)
    else $error("bad colon-substitute result");

  // Width follows the table: fixed font forces its width, proportional stored or narrow, colon set any.
  a_width_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_glyph_table == TABLE_FIXED && out_width_override == WIDTH_FIXED) ||
      (out_glyph_table == TABLE_PROP &&
        (out_width_override == WIDTH_STORED || out_width_override == WIDTH_NARROW)) ||
      out_glyph_table == TABLE_COLON)
    else $error("width does not match table");

endmodule : utg_checker

bind utf8_text_to_glyph_index_unit utg_checker u_utg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_text_byte       (in_text_byte),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_glyph_table    (out_glyph_table),
  .out_glyph_index    (out_glyph_index),
  .out_width_override (out_width_override)
);

`default_nettype wire
